[src/binary_rank_reduce_2x_top_macros.svh]
// Assertion macros for the binary 2x rank reduction block.
// Taken in by the top level; needs nothing else.
`ifndef BINARY_RANK_REDUCE_2X_TOP_MACROS_SVH
`define BINARY_RANK_REDUCE_2X_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BRR2X_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("brr2x: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BRR2X_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("brr2x: next-cycle check failed");

`endif

[src/brr2x_pkg.sv]
// Shared constants, types and the rank function of the binary 2x reduction.
// No dependencies; the queue, front end, back end and top level use it.
`timescale 1ns / 1ps

package brr2x_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned THR_W      = 3;
  localparam int unsigned WIDTH_W    = 13;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned KEEP_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_LINE_WORDS_DEF = 128;

  // The queue between front and back holds two requests.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  // Threshold limits; from THR_AND_FROM on, two-pixel pairs need both on.
  localparam logic [THR_W-1:0] THR_MIN      = 3'd1;
  localparam logic [THR_W-1:0] THR_MAX      = 3'd4;
  localparam logic [THR_W-1:0] THR_AND_FROM = 3'd3;

  // What the back end has to do with one request.
  typedef struct packed {
    logic [THR_W-1:0]  thr;        // clamped threshold, 1 to 4
    logic              vert;       // single-bit vertical or pass-through result
    logic              use_and;    // vertical pairing uses AND instead of OR
    logic              hold_op;    // left half only: keep it, give no result
    logic              odd_col;    // right half completes a held left half
    logic [KEEP_W-1:0] keep;       // number of leading bits kept, 1 to 32
    logic              row_end;
    logic              image_end;
  } brr2x_op_t;

  typedef struct packed {
    brr2x_op_t         op;
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] bottom;
  } brr2x_entry_t;

  // Rank decision for each 2x2 block of two words: bit k of the result is on
  // when at least thr of bits 2k+1 and 2k of both words are on.
  function automatic logic [HALF_W-1:0] rank_pack(input logic [WORD_W-1:0] top,
                                                  input logic [WORD_W-1:0] bottom,
                                                  input logic [THR_W-1:0]  thr);
    logic [2:0]        cnt;
    logic [HALF_W-1:0] r;
    r = '0;
    for (int k = 0; k < HALF_W; k++) begin
      cnt = 3'(top[2*k+1]) + 3'(top[2*k]) + 3'(bottom[2*k+1]) + 3'(bottom[2*k]);
      r[k] = (cnt >= thr);
    end
    return r;
  endfunction

endpackage

[src/brr2x_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module brr2x_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/brr2x_queue.sv]
// Two-entry request queue between the front and the back end.
// Depends on brr2x_pkg for its depth.
`timescale 1ns / 1ps

module brr2x_queue #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(brr2x_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(brr2x_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [brr2x_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(brr2x_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rptr_q];

  // Pointer and fill count.
  always_comb begin
    wptr_d = push_i ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

[src/brr2x_front.sv]
// Front end: configuration registers, input accept, row and column tracking,
// request classification and the top-row line buffer.
// Depends on brr2x_pkg and brr2x_ram.
`timescale 1ns / 1ps

module brr2x_front #(
  parameter int unsigned MAX_LINE_WORDS = brr2x_pkg::MAX_LINE_WORDS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [brr2x_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [brr2x_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [brr2x_pkg::WORD_W-1:0]         in_word_i,
  output logic                                 push_o,
  output brr2x_pkg::brr2x_entry_t              push_entry_o,
  input  logic                                 q_full_i
);

  localparam int unsigned COL_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
  localparam int unsigned W_MAX = MAX_LINE_WORDS * 32;

  // Configuration registers.
  logic [brr2x_pkg::THR_W-1:0]    thr_q;
  logic [brr2x_pkg::WIDTH_W-1:0]  width_q;
  logic [brr2x_pkg::HEIGHT_W-1:0] height_q;
  logic                           restart;

  // Position in the source image.
  logic [COL_W-1:0]               col_q, col_d;
  logic [brr2x_pkg::HEIGHT_W-1:0] row_q, row_d;

  // Stage that waits for the line buffer read.
  logic                           s1_valid_q, s1_valid_d;
  brr2x_pkg::brr2x_op_t           s1_op_q;
  logic [brr2x_pkg::WORD_W-1:0]   s1_word_q;
  logic                           s1_top_own_q;

  // Derived image geometry.
  logic [brr2x_pkg::THR_W-1:0]    thr_eff;
  logic [31:0]                    w_sat;
  logic [brr2x_pkg::WIDTH_W-1:0]  w_eff;
  logic [brr2x_pkg::HEIGHT_W-1:0] h_eff;
  logic [brr2x_pkg::HEIGHT_W-1:0] hev;
  logic [15:0]                    w16, dstw16, wpl16, steps16, outw16;
  logic [15:0]                    col16, o16, n16;
  logic                           rank_re, pair_last, has_next_step;

  // Classification of the current item.
  logic                           store;
  logic                           op_valid;
  logic                           top_own;
  brr2x_pkg::brr2x_op_t           op;
  logic                           acc;
  logic [brr2x_pkg::WORD_W-1:0]   ram_rdata;

  // Effective register values.
  always_comb begin
    if (thr_q < brr2x_pkg::THR_MIN) begin
      thr_eff = brr2x_pkg::THR_MIN;
    end else if (thr_q > brr2x_pkg::THR_MAX) begin
      thr_eff = brr2x_pkg::THR_MAX;
    end else begin
      thr_eff = thr_q;
    end
    w_sat = (width_q == '0) ? 32'd1 : 32'(width_q);
    if (w_sat > 32'(W_MAX)) begin
      w_sat = 32'(W_MAX);
    end
    w_eff = brr2x_pkg::WIDTH_W'(w_sat);
    h_eff = (height_q == '0) ? brr2x_pkg::HEIGHT_W'(1) : height_q;
    hev   = {h_eff[brr2x_pkg::HEIGHT_W-1:1], 1'b0};
  end

  // Word counts of a row and the place of the current word in the output.
  always_comb begin
    w16           = 16'(w_eff);
    dstw16        = w16 >> 1;
    wpl16         = (w16 + 16'd31) >> 5;
    steps16       = (dstw16 + 16'd15) >> 4;
    outw16        = (dstw16 + 16'd31) >> 5;
    col16         = 16'(col_q);
    o16           = col16 >> 1;
    n16           = dstw16 - (o16 << 5);
    rank_re       = (o16 + 16'd1 == outw16);
    has_next_step = (col16 + 16'd1 < steps16);
    pair_last     = ({1'b0, row_q} + 17'd1 == {1'b0, hev});
  end

  // Decide what the item does: store a top row word, or send a request.
  always_comb begin
    store          = 1'b0;
    op_valid       = 1'b0;
    top_own        = 1'b0;
    op.thr         = thr_eff;
    op.vert        = 1'b0;
    op.use_and     = 1'b0;
    op.hold_op     = !col_q[0] && has_next_step;
    op.odd_col     = col_q[0];
    op.keep        = (n16 >= 16'd32) ? brr2x_pkg::KEEP_W'(32) : n16[brr2x_pkg::KEEP_W-1:0];
    op.row_end     = rank_re;
    op.image_end   = rank_re && pair_last;
    priority if (w_eff == brr2x_pkg::WIDTH_W'(1) && h_eff == brr2x_pkg::HEIGHT_W'(1)) begin
      // One pixel: the leftmost bit passes through.
      op_valid     = 1'b1;
      top_own      = 1'b1;
      op.vert      = 1'b1;
      op.hold_op   = 1'b0;
      op.keep      = brr2x_pkg::KEEP_W'(1);
      op.row_end   = 1'b1;
      op.image_end = 1'b1;
    end else if (h_eff < brr2x_pkg::HEIGHT_W'(2)) begin
      // One row: the word pairs with itself, giving horizontal pairs.
      op_valid     = (col16 < steps16);
      top_own      = 1'b1;
      op.image_end = rank_re;
    end else if (w_eff == brr2x_pkg::WIDTH_W'(1)) begin
      // One column: rows pair vertically on the leftmost bit.
      store        = (row_q < hev) && !row_q[0];
      op_valid     = (row_q < hev) && row_q[0];
      op.vert      = 1'b1;
      op.use_and   = (thr_eff >= brr2x_pkg::THR_AND_FROM);
      op.hold_op   = 1'b0;
      op.keep      = brr2x_pkg::KEEP_W'(1);
      op.row_end   = 1'b1;
      op.image_end = pair_last;
    end else begin
      store        = (row_q < hev) && (col16 < steps16) && !row_q[0];
      op_valid     = (row_q < hev) && (col16 < steps16) && row_q[0];
    end
  end

  // The item is taken unless the waiting stage cannot move into the queue.
  assign in_ready_o = !s1_valid_q || !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !q_full_i;

  // Top-row line buffer, addressed by the word column.
  brr2x_ram #(
    .WIDTH (brr2x_pkg::WORD_W),
    .DEPTH (MAX_LINE_WORDS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (acc && store),
    .waddr_i (col_q),
    .wdata_i (in_word_i),
    .re_i    (acc && op_valid),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    push_entry_o.op     = s1_op_q;
    push_entry_o.top    = s1_top_own_q ? s1_word_q : ram_rdata;
    push_entry_o.bottom = s1_word_q;
  end

  // Position counters; any register write restarts the image.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (col16 + 16'd1 >= wpl16) begin
        col_d = '0;
        if ({1'b0, row_q} + 17'd1 >= {1'b0, h_eff}) begin
          row_d = '0;
        end else begin
          row_d = row_q + brr2x_pkg::HEIGHT_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // Stage occupancy.
  always_comb begin
    if (acc) begin
      s1_valid_d = op_valid;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // Configuration write decode.
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        brr2x_pkg::CFG_RANK_THRESHOLD,
        brr2x_pkg::CFG_IMAGE_WIDTH,
        brr2x_pkg::CFG_IMAGE_HEIGHT: restart = 1'b1;
        default:                     restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= brr2x_pkg::THR_W'(1);
      width_q  <= brr2x_pkg::WIDTH_W'(1);
      height_q <= brr2x_pkg::HEIGHT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        brr2x_pkg::CFG_RANK_THRESHOLD: thr_q    <= cfg_data_i[brr2x_pkg::THR_W-1:0];
        brr2x_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg_data_i[brr2x_pkg::WIDTH_W-1:0];
        brr2x_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i[brr2x_pkg::HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Request payload of the waiting stage.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_op_q      <= op;
      s1_word_q    <= in_word_i;
      s1_top_own_q <= top_own;
    end
  end

endmodule

[src/brr2x_back.sv]
// Back end: rank decision, half-word pairing, padding mask and the output
// register. Depends on brr2x_pkg.
`timescale 1ns / 1ps

module brr2x_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  brr2x_pkg::brr2x_entry_t       q_entry_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brr2x_pkg::WORD_W-1:0]  out_word_o,
  output logic                          out_row_end_o,
  output logic                          out_image_end_o
);

  logic [brr2x_pkg::HALF_W-1:0] hold_q;
  logic                         out_valid_q, out_valid_d;
  logic [brr2x_pkg::WORD_W-1:0] out_word_q;
  logic                         out_row_end_q;
  logic                         out_image_end_q;

  logic [brr2x_pkg::HALF_W-1:0] half;
  logic                         vert_bit;
  logic [brr2x_pkg::WORD_W-1:0] res;
  logic [brr2x_pkg::WORD_W-1:0] mask;
  logic                         load;

  // Result of the request at the head of the queue.
  always_comb begin
    half     = brr2x_pkg::rank_pack(q_entry_i.top, q_entry_i.bottom, q_entry_i.op.thr);
    vert_bit = q_entry_i.op.use_and ? (q_entry_i.top[31] & q_entry_i.bottom[31])
                                    : (q_entry_i.top[31] | q_entry_i.bottom[31]);
    if (q_entry_i.op.vert) begin
      res = {vert_bit, 31'b0};
    end else if (q_entry_i.op.odd_col) begin
      res = {hold_q, half};
    end else begin
      res = {half, brr2x_pkg::HALF_W'(0)};
    end
    mask = ~({brr2x_pkg::WORD_W{1'b1}} >> q_entry_i.op.keep);
  end

  // A held left half never waits on the output; a result waits for room.
  assign q_pop_o = q_valid_i && (q_entry_i.op.hold_op || !out_valid_q || out_ready_i);
  assign load    = q_pop_o && !q_entry_i.op.hold_op;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hold_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o && q_entry_i.op.hold_op) begin
        hold_q <= half;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q      <= res & mask;
      out_row_end_q   <= q_entry_i.op.row_end;
      out_image_end_q <= q_entry_i.op.image_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_word_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_image_end_o = out_image_end_q;

endmodule

[src/binary_rank_reduce_2x_top.sv]
// Top level of the binary 2x rank reduction: front end, request queue, back end.
// Depends on brr2x_pkg, brr2x_front, brr2x_queue, brr2x_back and the macro header.
//
//   Channel   | Direction | Carries
//   ----------+-----------+-----------------------------------------------------
//   s_axis    | in        | tdata: pixel_word[31:0]
//   m_axis    | out       | tdata: out_word[31:0]; tlast: row_end; tuser: image_end
//   cfg       | in        | index 0 rank_threshold, 1 image_width, 2 image_height
//
// One source word is taken per cycle unless the input side is held. Once its
// last source word is taken, a result moves via line buffer read, queue, output.
// Reset clears the counters, the queue and the output register; the line buffer
// needs no clearing, so items are taken from the first cycle after reset.
// Output stalls fill the two-entry queue first and then hold the input side.
`timescale 1ns / 1ps
`include "binary_rank_reduce_2x_top_macros.svh"

module binary_rank_reduce_2x_top #(
  parameter int unsigned MAX_LINE_WORDS = brr2x_pkg::MAX_LINE_WORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brr2x_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [brr2x_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [brr2x_pkg::WORD_W-1:0]      s_axis_tdata,   // [31:0] pixel_word
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [brr2x_pkg::WORD_W-1:0]      m_axis_tdata,   // [31:0] out_word
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser    // [0] image_end
);

  localparam int unsigned ENTRY_W = $bits(brr2x_pkg::brr2x_entry_t);

  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_valid;
  brr2x_pkg::brr2x_entry_t push_entry;
  brr2x_pkg::brr2x_entry_t head_entry;
  logic [ENTRY_W-1:0]      head_bits;

  // Accept, classify and buffer top rows.
  brr2x_front #(
    .MAX_LINE_WORDS (MAX_LINE_WORDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_word_i    (s_axis_tdata),
    .push_o       (q_push),
    .push_entry_o (push_entry),
    .q_full_i     (q_full)
  );

  // Requests between the two halves.
  brr2x_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_bits)
  );

  assign head_entry = head_bits;

  // Rank decision and output.
  brr2x_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (head_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_word_o      (m_axis_tdata),
    .out_row_end_o   (m_axis_tlast),
    .out_image_end_o (m_axis_tuser)
  );

  // The front end never pushes into a full queue.
  `BRR2X_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, q_push, !q_full)
  // The end of the image is always the end of a reduced row.
  `BRR2X_ASSERT_IMP(a_image_end_row_end, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // A queued request is not lost unless it was popped.
  `BRR2X_ASSERT_NEXT(a_queue_keeps, clk_i, rst_ni, q_valid && !q_pop, q_valid)

endmodule
